// ----- hdl/zlhp_pkg.sv -----
// shared types, constants and helpers for the zip local header parser
// no dependencies; used by every module of the block
package zlhp_pkg;

    localparam int HDR_BYTES = 30;
    localparam int POS_W     = 5;
    localparam int DATA_W    = 208;

    localparam logic [7:0] MAGIC_B0 = 8'h50;
    localparam logic [7:0] MAGIC_B1 = 8'h4B;
    localparam logic [7:0] MAGIC_B2 = 8'h03;
    localparam logic [7:0] MAGIC_B3 = 8'h04;

    // item kind on the input stream
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_EOF  = 1'b1;

    typedef enum logic [3:0] {
        ST_OK          = 4'd0,
        ST_SHORT       = 4'd1,
        ST_BAD_MAGIC   = 4'd2,
        ST_TR_VERSION  = 4'd3,
        ST_TR_FLAGS    = 4'd4,
        ST_TR_METHOD   = 4'd5,
        ST_TR_TIME     = 4'd6,
        ST_TR_DATE     = 4'd7,
        ST_TR_CRC      = 4'd8,
        ST_TR_CSIZE    = 4'd9,
        ST_TR_USIZE    = 4'd10,
        ST_TR_NAME_LEN = 4'd11,
        ST_TR_EXTRA    = 4'd12
    } status_t;

    typedef struct packed {
        status_t      status;
        logic [15:0]  version_needed;
        logic [15:0]  flag_bits;
        logic [15:0]  method;
        logic [15:0]  mod_time;
        logic [15:0]  mod_date;
        logic [31:0]  crc_value;
        logic [31:0]  compressed_size;
        logic [31:0]  uncompressed_size;
        logic [15:0]  name_length;
        logic [15:0]  extra_length;
    } result_t;

    // status for an end of file seen at byte count pos
    function automatic status_t truncated_code(input logic [POS_W-1:0] pos);
        status_t code;
        if      (pos < 5'd4)  code = ST_SHORT;
        else if (pos < 5'd6)  code = ST_TR_VERSION;
        else if (pos < 5'd8)  code = ST_TR_FLAGS;
        else if (pos < 5'd10) code = ST_TR_METHOD;
        else if (pos < 5'd12) code = ST_TR_TIME;
        else if (pos < 5'd14) code = ST_TR_DATE;
        else if (pos < 5'd18) code = ST_TR_CRC;
        else if (pos < 5'd22) code = ST_TR_CSIZE;
        else if (pos < 5'd26) code = ST_TR_USIZE;
        else if (pos < 5'd28) code = ST_TR_NAME_LEN;
        else                  code = ST_TR_EXTRA;
        return code;
    endfunction

endpackage

// ----- hdl/zlhp_capture.sv -----
// byte position counter, magic check and header byte store
// depends on zlhp_pkg
module zlhp_capture (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  logic              kind,
    input  logic [7:0]        data_byte,
    output logic              res_valid,
    output zlhp_pkg::result_t res
);
    import zlhp_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic             reported_reg, reported_next;
    logic             magic_ok_reg, magic_ok_next;
    logic [7:0]       hdr_reg [4:HDR_BYTES-2];
    logic             store_en;
    logic [7:0]       magic_exp;

    always_comb
    begin
        unique case (pos_reg[1:0])
            2'd0:    magic_exp = MAGIC_B0;
            2'd1:    magic_exp = MAGIC_B1;
            2'd2:    magic_exp = MAGIC_B2;
            default: magic_exp = MAGIC_B3;
        endcase
    end

    always_comb
    begin
        pos_next      = pos_reg;
        reported_next = reported_reg;
        magic_ok_next = magic_ok_reg;
        store_en      = 1'b0;
        res_valid     = 1'b0;
        res           = '0;
        res.status    = ST_OK;
        if (take)
        begin
            if (kind == KIND_EOF)
            begin
                res_valid     = !reported_reg;
                res.status    = truncated_code(pos_reg);
                pos_next      = '0;
                reported_next = 1'b0;
                magic_ok_next = 1'b1;
            end
            else if (!reported_reg && pos_reg < POS_W'(HDR_BYTES))
            begin
                store_en = 1'b1;
                pos_next = pos_reg + 1'b1;
                if (pos_reg < 5'd4)
                    magic_ok_next = magic_ok_reg && (data_byte == magic_exp);
                if (pos_reg == 5'd3 && !magic_ok_next)
                begin
                    res_valid     = 1'b1;
                    res.status    = ST_BAD_MAGIC;
                    reported_next = 1'b1;
                end
                else if (pos_reg == POS_W'(HDR_BYTES - 1))
                begin
                    // last header byte arrives with the request itself
                    res_valid             = 1'b1;
                    reported_next         = 1'b1;
                    res.version_needed    = {hdr_reg[5],  hdr_reg[4]};
                    res.flag_bits         = {hdr_reg[7],  hdr_reg[6]};
                    res.method            = {hdr_reg[9],  hdr_reg[8]};
                    res.mod_time          = {hdr_reg[11], hdr_reg[10]};
                    res.mod_date          = {hdr_reg[13], hdr_reg[12]};
                    res.crc_value         = {hdr_reg[17], hdr_reg[16],
                                             hdr_reg[15], hdr_reg[14]};
                    res.compressed_size   = {hdr_reg[21], hdr_reg[20],
                                             hdr_reg[19], hdr_reg[18]};
                    res.uncompressed_size = {hdr_reg[25], hdr_reg[24],
                                             hdr_reg[23], hdr_reg[22]};
                    res.name_length       = {hdr_reg[27], hdr_reg[26]};
                    res.extra_length      = {data_byte,   hdr_reg[28]};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            reported_reg <= 1'b0;
            magic_ok_reg <= 1'b1;
        end
        else
        begin
            pos_reg      <= pos_next;
            reported_reg <= reported_next;
            magic_ok_reg <= magic_ok_next;
        end
    end

    // header bytes, each written at its own position
    always_ff @(posedge clk)
    begin
        for (int i = 4; i <= HDR_BYTES - 2; i++)
        begin
            if (store_en && pos_reg == POS_W'(i))
                hdr_reg[i] <= data_byte;
        end
    end

endmodule

// ----- hdl/zlhp_out_stage.sv -----
// result register between the parser logic and the output stream
// depends on zlhp_pkg
module zlhp_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              res_valid,
    input  zlhp_pkg::result_t res,
    output logic              can_take,
    output logic              out_valid,
    input  logic              out_ready,
    output zlhp_pkg::result_t out_res
);
    import zlhp_pkg::*;

    logic    valid_reg, valid_next;
    result_t res_reg;

    assign can_take  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (can_take)
            valid_next = res_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (can_take && res_valid)
            res_reg <= res;
    end

endmodule

// ----- hdl/zip_local_header_parser.sv -----
// top level of the zip local file header parser
// depends on zlhp_pkg, zlhp_capture and zlhp_out_stage
//
// channel   dir  tdata                 tuser
// s_axis    in   data_byte (8)         kind (1): 0 data byte, 1 end of file
// m_axis    out  header fields (208)   status (4)
//
// one request per cycle; a request that yields a result has it on m_tvalid
// the next cycle, set by the single result register
// the position counter, the reported flag, the magic flag and the stored
// header bytes carry state between requests; reset clears all but the header
// bytes, and clears the result register valid bit
// input stalls only while a result waits and m_tready is low
module zip_local_header_parser (
    input  logic         clk,
    input  logic         rst_n,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // data_byte[7:0]
    input  logic         s_tuser,   // kind
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // version_needed[15:0], flag_bits[31:16], method[47:32], mod_time[63:48],
    // mod_date[79:64], crc_value[111:80], compressed_size[143:112],
    // uncompressed_size[175:144], name_length[191:176], extra_length[207:192]
    output logic [207:0] m_tdata,
    output logic [3:0]   m_tuser    // status
);
    import zlhp_pkg::*;

    logic    take;
    logic    can_take;
    logic    res_valid;
    result_t res;
    result_t out_res;

    // a request is taken whenever the result register can move
    assign s_tready = can_take;
    assign take     = s_tvalid && can_take;

    zlhp_capture u_capture (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .kind      (s_tuser),
        .data_byte (s_tdata),
        .res_valid (res_valid),
        .res       (res)
    );

    zlhp_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .can_take  (can_take),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    // first field in the low bits
    assign m_tuser = out_res.status;
    assign m_tdata = {out_res.extra_length, out_res.name_length,
                      out_res.uncompressed_size, out_res.compressed_size,
                      out_res.crc_value, out_res.mod_date, out_res.mod_time,
                      out_res.method, out_res.flag_bits, out_res.version_needed};

endmodule
